// ===== src/sfd_pkg.sv =====
// Shared types and constants for the serial frame deframer with XOR check.
package sfd_pkg;

   localparam int CNT_W     = 7;      // width of length and fill counters
   localparam int RESULT_CAP = 64;    // most results one frame may yield

   localparam logic [7:0] START_BYTE_RESET   = 8'hAA;
   localparam logic [6:0] LENGTH_LIMIT_RESET = 7'd64;

   // register indexes on the csr port
   localparam logic CSR_START_BYTE   = 1'b0;
   localparam logic CSR_LENGTH_LIMIT = 1'b1;

   typedef enum logic [2:0] {
      PH_HUNT    = 3'd0,
      PH_ID      = 3'd1,
      PH_LEN     = 3'd2,
      PH_PAYLOAD = 3'd3,
      PH_CHECK   = 3'd4
   } phase_type;

   // one checked frame waiting for the back end
   typedef struct packed {
      logic [7:0]       id;
      logic [CNT_W-1:0] len;
      logic             bank;
   } frame_desc_type;

   // payload store write from the parser
   typedef struct packed {
      logic             en;
      logic             bank;
      logic [CNT_W-1:0] idx;
      logic [7:0]       data;
   } store_wr_type;

   // descriptor queue status
   typedef struct packed {
      logic           full;
      logic           empty;
      frame_desc_type head;
   } queue_stat_type;

endpackage

// ===== src/sfd_front.sv =====
// Frame parser: hunts for the start byte, checks length and XOR, writes payload.
module sfd_front #(
   parameter int MAX_PAYLOAD = 64
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [7:0]               req_tdata,
   input  logic [7:0]               start_byte,
   input  logic [6:0]               length_limit,
   input  logic                     q_full,
   output logic                     push,
   output sfd_pkg::frame_desc_type  push_desc,
   output sfd_pkg::store_wr_type    store_wr
);
   import sfd_pkg::*;

   localparam int CAP = (MAX_PAYLOAD < RESULT_CAP) ? MAX_PAYLOAD : RESULT_CAP;

   phase_type        phase_ff, phase_in;
   logic [7:0]       id_ff, id_in;
   logic [CNT_W-1:0] len_ff, len_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic [7:0]       chk_ff, chk_in;
   logic             bank_ff, bank_in;
   logic [CNT_W-1:0] eff_limit;
   logic [CNT_W-1:0] fill_next;
   logic             accept;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;
   assign eff_limit  = (length_limit > CNT_W'(CAP)) ? CNT_W'(CAP) : length_limit;
   assign fill_next  = fill_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         id_ff    <= '0;
         len_ff   <= '0;
         fill_ff  <= '0;
         chk_ff   <= '0;
         bank_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         id_ff    <= id_in;
         len_ff   <= len_in;
         fill_ff  <= fill_in;
         chk_ff   <= chk_in;
         bank_ff  <= bank_in;
      end
   end

   always_comb begin
      phase_in       = phase_ff;
      id_in          = id_ff;
      len_in         = len_ff;
      fill_in        = fill_ff;
      chk_in         = chk_ff;
      bank_in        = bank_ff;
      push           = 1'b0;
      push_desc.id   = id_ff;
      push_desc.len  = len_ff;
      push_desc.bank = bank_ff;
      store_wr.en    = 1'b0;
      store_wr.bank  = bank_ff;
      store_wr.idx   = fill_ff;
      store_wr.data  = req_tdata;
      if (accept) begin
         case (phase_ff)
            PH_ID: begin
               id_in    = req_tdata;
               chk_in   = req_tdata;
               phase_in = PH_LEN;
            end
            PH_LEN: begin
               if (CNT_W'(req_tdata) > eff_limit || req_tdata[7]) begin
                  phase_in = PH_HUNT;
                  id_in    = '0;
                  len_in   = '0;
                  fill_in  = '0;
                  chk_in   = '0;
               end else begin
                  len_in   = CNT_W'(req_tdata);
                  fill_in  = '0;
                  chk_in   = chk_ff ^ req_tdata;
                  phase_in = (req_tdata == 8'd0) ? PH_CHECK : PH_PAYLOAD;
               end
            end
            PH_PAYLOAD: begin
               store_wr.en = 1'b1;
               chk_in      = chk_ff ^ req_tdata;
               fill_in     = fill_next;
               if (fill_next >= len_ff) phase_in = PH_CHECK;
            end
            PH_CHECK: begin
               if (req_tdata == chk_ff) begin
                  push    = 1'b1;
                  bank_in = !bank_ff;
               end
               phase_in = PH_HUNT;
               id_in    = '0;
               len_in   = '0;
               fill_in  = '0;
               chk_in   = '0;
            end
            default: begin
               phase_in = (req_tdata == start_byte) ? PH_ID : PH_HUNT;
               id_in    = '0;
               len_in   = '0;
               fill_in  = '0;
               chk_in   = '0;
            end
         endcase
      end
   end

endmodule

// ===== src/sfd_queue.sv =====
// Two-entry descriptor queue between parser and emitter; slot matches store bank.
module sfd_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  sfd_pkg::frame_desc_type  push_desc,
   input  logic                     pop,
   output sfd_pkg::queue_stat_type  stat
);
   import sfd_pkg::*;

   frame_desc_type slot_ff [2];
   logic           wr_ptr_ff, wr_ptr_in;
   logic           rd_ptr_ff, rd_ptr_in;
   logic [1:0]     count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= push_desc;
   end

   assign stat.full  = (count_ff == 2'd2);
   assign stat.empty = (count_ff == 2'd0);
   assign stat.head  = slot_ff[rd_ptr_ff];

endmodule

// ===== src/sfd_back.sv =====
// Result emitter: holds the two-bank payload store and streams frames out.
module sfd_back #(
   parameter int MAX_PAYLOAD = 64
) (
   input  logic                     clock,
   input  logic                     reset,
   input  sfd_pkg::store_wr_type    store_wr,
   input  sfd_pkg::queue_stat_type  q_stat,
   output logic                     pop,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [31:0]              rsp_tdata,
   output logic                     rsp_tuser,
   output logic                     rsp_tlast
);
   import sfd_pkg::*;

   localparam int AW    = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
   localparam int DEPTH = 2 * (1 << AW);

   logic [7:0]       mem [DEPTH];
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic             advance, issue, last_issue;

   // read stage
   logic             s1_valid_ff;
   logic [7:0]       rd_data_ff;
   logic [7:0]       s1_id_ff;
   logic [CNT_W-1:0] s1_len_ff;
   logic [5:0]       s1_idx_ff;
   logic             s1_has_ff, s1_last_ff;

   // output stage
   logic             out_valid_ff;
   logic [7:0]       out_id_ff, out_byte_ff;
   logic [CNT_W-1:0] out_len_ff;
   logic [5:0]       out_idx_ff;
   logic             out_has_ff, out_last_ff;

   assign advance    = !out_valid_ff || rsp_tready;
   assign issue      = advance && !q_stat.empty;
   assign last_issue = issue && (q_stat.head.len == '0 ||
                                 CNT_W'(idx_ff + 1'b1) == q_stat.head.len);
   assign pop        = last_issue;
   assign idx_in     = last_issue ? '0 : (issue ? CNT_W'(idx_ff + 1'b1) : idx_ff);

   always_ff @(posedge clock) begin
      if (store_wr.en) mem[{store_wr.bank, AW'(store_wr.idx)}] <= store_wr.data;
      if (issue) rd_data_ff <= mem[{q_stat.head.bank, AW'(idx_ff)}];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         idx_ff <= idx_in;
         if (advance) begin
            s1_valid_ff  <= issue;
            out_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         s1_id_ff   <= q_stat.head.id;
         s1_len_ff  <= q_stat.head.len;
         s1_idx_ff  <= idx_ff[5:0];
         s1_has_ff  <= (q_stat.head.len != '0);
         s1_last_ff <= last_issue;
      end
      if (advance && s1_valid_ff) begin
         out_id_ff   <= s1_id_ff;
         out_len_ff  <= s1_len_ff;
         out_idx_ff  <= s1_idx_ff;
         out_byte_ff <= s1_has_ff ? rd_data_ff : 8'd0;
         out_has_ff  <= s1_has_ff;
         out_last_ff <= s1_last_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {3'b000, out_byte_ff, out_idx_ff, out_len_ff, out_id_ff};
   assign rsp_tuser  = out_has_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

// ===== src/serial_frame_deframer_xor_check_core.sv =====
// Top level of the serial frame deframer with XOR check.
// Input: one byte per cycle while fewer than two checked frames await output.
// Output: one result per cycle while rsp_tready is high; the first result of a frame
//   follows the check byte transaction through the queue, the registered store read
//   and the output register.
// A frame of n payload bytes yields n results (1 for an empty frame).
// Reset (synchronous, active high) returns the parser to the hunt and empties
// the queue and output pipeline; start byte 0xAA, length limit 64.
module serial_frame_deframer_xor_check_core #(
   parameter int MAX_PAYLOAD = 64
) (
   input  logic        clock,
   input  logic        reset,
   // received byte stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   // frame result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [7:0] frame_id, [14:8] frame_length,
                                    // [20:15] byte_index, [28:21] payload_byte
   output logic        rsp_tuser,   // has_byte
   output logic        rsp_tlast,   // last
   // register writes
   input  logic        csr_we,
   input  logic        csr_addr,    // 0 start_byte, 1 length_limit
   input  logic [7:0]  csr_wdata
);
   import sfd_pkg::*;

   logic [7:0]     start_byte_ff;
   logic [6:0]     length_limit_ff;
   logic           push, pop;
   frame_desc_type push_desc;
   store_wr_type   store_wr;
   queue_stat_type q_stat;

   // Config registers; the user must write them only while the block is quiet (not enforced).
   always_ff @(posedge clock) begin
      if (reset) begin
         start_byte_ff   <= START_BYTE_RESET;
         length_limit_ff <= LENGTH_LIMIT_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_START_BYTE:   start_byte_ff   <= csr_wdata;
            CSR_LENGTH_LIMIT: length_limit_ff <= csr_wdata[6:0];
            default: ;
         endcase
      end
   end

   // Front: parses the byte stream and fills the payload bank it owns.
   sfd_front #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .start_byte   (start_byte_ff),
      .length_limit (length_limit_ff),
      .q_full       (q_stat.full),
      .push         (push),
      .push_desc    (push_desc),
      .store_wr     (store_wr)
   );

   // Queue of checked frames; each entry pins one store bank.
   sfd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_desc (push_desc),
      .pop       (pop),
      .stat      (q_stat)
   );

   // Back: reads the head frame's bank and drives the result stream.
   sfd_back #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_back (
      .clock      (clock),
      .reset      (reset),
      .store_wr   (store_wr),
      .q_stat     (q_stat),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // parser never pushes into a full queue
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      !(push && q_stat.full)) else $error("push into full queue");

   // emitter never pops an empty queue
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      !(pop && q_stat.empty)) else $error("pop from empty queue");

   // empty-frame result is alone: last set, payload zero
   a_empty_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tlast && rsp_tdata[28:21] == 8'd0)
      else $error("malformed empty-frame result");

   // payload results stay inside the frame length
   a_index_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> {1'b0, rsp_tdata[20:15]} < rsp_tdata[14:8])
      else $error("byte index beyond frame length");

endmodule

// ===== bench/tb_serial_frame_deframer_xor_check_core.sv =====
// Testbench for the serial frame deframer with XOR check: stimulus, predictor and result checks.
module tb_serial_frame_deframer_xor_check_core;
   import sfd_pkg::*;

   localparam int STORE_DEPTH    = 64;    // payload store depth given to the core
   localparam int SETTLE_CYCLES  = 12;    // wait after drain; margin on top of the core pipeline
   localparam int HOLD_CYCLES    = 300;   // long result-side hold-off to fill the core
   localparam int WATCHDOG_LIMIT = 3000;  // cycles with no transaction before giving up

   // one result transaction as the core should present it
   typedef struct {
      logic [7:0] id;
      logic [6:0] len;
      logic [5:0] idx;
      logic [7:0] data;
      logic       has;
      logic       last;
   } frame_beat_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;
   logic        csr_we = 1'b0;
   logic        csr_addr = CSR_START_BYTE;
   logic [7:0]  csr_wdata = 8'h00;

   // stimulus and scoreboard
   logic [7:0]     tx_bytes[$];        // received bytes still to be offered
   frame_beat_type expected_beats[$];  // predicted results, oldest first
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   logic        hold_go = 1'b0;     // set once to start the long hold-off
   int          hold_cnt = 0;
   int          idle_cycles = 0;
   int          mismatch_count = 0;

   // predictor copy of the parser state and registers
   logic [7:0]  cfg_start;
   logic [6:0]  cfg_limit;
   phase_type   rx_phase;
   logic [7:0]  rx_id;
   logic [6:0]  rx_len;
   logic [6:0]  fill_count;
   logic [7:0]  xor_sum;
   logic [7:0]  rx_payload[STORE_DEPTH];

   serial_frame_deframer_xor_check_core #(
      .MAX_PAYLOAD(STORE_DEPTH)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #6 clock = ~clock;

   // ------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------

   // the store never takes more than its depth, whatever the register says
   function automatic int cap_limit();
      return (cfg_limit > STORE_DEPTH) ? STORE_DEPTH : int'(cfg_limit);
   endfunction

   function void back_to_hunt();
      rx_phase   = PH_HUNT;
      rx_id      = 8'h00;
      rx_len     = 7'd0;
      fill_count = 7'd0;
      xor_sum    = 8'h00;
   endfunction

   function void reset_predictor();
      cfg_start = START_BYTE_RESET;
      cfg_limit = LENGTH_LIMIT_RESET;
      foreach (rx_payload[i]) rx_payload[i] = 8'h00;
      back_to_hunt();
   endfunction

   // one accepted byte; a good check byte queues the frame's results
   function void parse_rx_byte(input logic [7:0] b);
      frame_beat_type beat;
      case (rx_phase)
         PH_ID: begin
            rx_id    = b;
            xor_sum  = b;
            rx_phase = PH_LEN;
         end
         PH_LEN: begin
            if (int'(b) > cap_limit()) begin
               back_to_hunt();          // too long: drop at the length byte
            end else begin
               rx_len     = b[6:0];
               fill_count = 7'd0;
               xor_sum    = xor_sum ^ b;
               rx_phase   = (b == 8'h00) ? PH_CHECK : PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            rx_payload[fill_count[5:0]] = b;
            xor_sum    = xor_sum ^ b;
            fill_count = fill_count + 7'd1;
            if (fill_count >= rx_len) rx_phase = PH_CHECK;
         end
         PH_CHECK: begin
            if (b == xor_sum) begin
               beat.id  = rx_id;
               beat.len = rx_len;
               if (rx_len == 7'd0) begin
                  // empty frame still yields one marker result
                  beat.idx  = 6'd0;
                  beat.data = 8'h00;
                  beat.has  = 1'b0;
                  beat.last = 1'b1;
                  expected_beats.push_back(beat);
               end else begin
                  for (int k = 0; k < rx_len; k++) begin
                     beat.idx  = k[5:0];
                     beat.data = rx_payload[k];
                     beat.has  = 1'b1;
                     beat.last = (k + 1 == rx_len);
                     expected_beats.push_back(beat);
                  end
               end
            end
            back_to_hunt();
         end
         default: begin
            // unused codes behave as the hunt
            back_to_hunt();
            if (b == cfg_start) rx_phase = PH_ID;
         end
      endcase
   endfunction

   // ------------------------------------------------------------------
   // Checking
   // ------------------------------------------------------------------

   task automatic note_mismatch(input string field, input logic [31:0] got,
                                input logic [31:0] want);
      $display("mismatch at %0t: %s got %0h expected %0h", $realtime, field, got, want);
      mismatch_count++;
   endtask

   task automatic check_beat();
      frame_beat_type want;
      if (expected_beats.size() == 0) begin
         note_mismatch("result with nothing expected", rsp_tdata, 32'h0);
         return;
      end
      want = expected_beats.pop_front();
      if (rsp_tdata[7:0] !== want.id)     note_mismatch("frame_id", rsp_tdata[7:0], want.id);
      if (rsp_tdata[14:8] !== want.len)   note_mismatch("frame_length", rsp_tdata[14:8], want.len);
      if (rsp_tdata[20:15] !== want.idx)  note_mismatch("byte_index", rsp_tdata[20:15], want.idx);
      if (rsp_tdata[28:21] !== want.data) note_mismatch("payload_byte", rsp_tdata[28:21], want.data);
      if (rsp_tdata[31:29] !== 3'b000)    note_mismatch("tdata padding", rsp_tdata[31:29], 0);
      if (rsp_tuser !== want.has)         note_mismatch("has_byte", rsp_tuser, want.has);
      if (rsp_tlast !== want.last)        note_mismatch("last", rsp_tlast, want.last);
   endtask

   // ------------------------------------------------------------------
   // Driver, receiver, monitor, watchdog
   // ------------------------------------------------------------------

   // Byte driver: a new transaction is offered only once the previous one
   // was taken, so tvalid never drops while an item is pending.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (tx_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            req_tvalid <= 1'b1;
            req_tdata  <= tx_bytes.pop_front();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Result receiver: random stalls, plus one long hold-off once hold_go is
   // raised, so the core's frame queue fills and it backs up its input.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_go && hold_cnt < HOLD_CYCLES) begin
         rsp_tready <= 1'b0;
         hold_cnt   <= hold_cnt + 1;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // Monitor: handshakes are sampled at the edge, before any NBA update.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) parse_rx_byte(req_tdata);
         if (rsp_tvalid && rsp_tready) check_beat();
      end
   end

   // Watchdog: any transaction or register write restarts the count.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
         $display("simulation failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------

   // both registers, back to back; only called while the core is idle
   task automatic set_config(input logic [7:0] sb, input logic [6:0] lim);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= CSR_START_BYTE;
      csr_wdata <= sb;
      @(posedge clock);
      csr_addr  <= CSR_LENGTH_LIMIT;
      csr_wdata <= {1'b0, lim};
      @(posedge clock);
      csr_we    <= 1'b0;
      cfg_start = sb;
      cfg_limit = lim;
   endtask

   // mostly short payloads, sometimes empty or exactly at the limit
   function automatic int pick_length(input int eff);
      int r;
      if (eff == 0) return 0;
      r = $urandom_range(0, 19);
      if (r == 0) return eff;
      if (r == 1) return 0;
      return $urandom_range(1, (eff < 8) ? eff : 8);
   endfunction

   // well-formed frame with random id and payload; spoil flips check bits
   task automatic queue_frame(input int n, input bit spoil);
      logic [7:0] id;
      logic [7:0] b;
      logic [7:0] sum;
      id  = 8'($urandom_range(0, 255));
      sum = id ^ n[7:0];
      tx_bytes.push_back(cfg_start);
      tx_bytes.push_back(id);
      tx_bytes.push_back(n[7:0]);
      for (int k = 0; k < n; k++) begin
         b = 8'($urandom_range(0, 255));
         sum = sum ^ b;
         tx_bytes.push_back(b);
      end
      if (spoil) sum = sum ^ 8'($urandom_range(1, 255));
      tx_bytes.push_back(sum);
   endtask

   // random mix: good frames dominate, then bad checks, overlong lengths, noise
   task automatic fill_phase(input int target, input bit mostly_good);
      int added;
      int pick;
      int eff;
      int n;
      added = 0;
      eff = cap_limit();
      while (added < target) begin
         pick = $urandom_range(0, 99);
         if (pick < (mostly_good ? 90 : 65)) begin
            n = pick_length(eff);
            queue_frame(n, 1'b0);
            added += n + 4;
         end else if (pick < 80 || (mostly_good && pick < 95)) begin
            n = pick_length(eff);
            queue_frame(n, 1'b1);
            added += n + 4;
         end else if (pick < 90) begin
            tx_bytes.push_back(cfg_start);
            tx_bytes.push_back(8'($urandom_range(0, 255)));
            tx_bytes.push_back(8'($urandom_range(eff + 1, 255)));
            added += 3;
         end else begin
            tx_bytes.push_back(8'($urandom_range(0, 255)));
            added += 1;
         end
      end
   endtask

   // wait on the falling edge so queue and handshake state have settled
   task automatic drain();
      do @(negedge clock);
      while (tx_bytes.size() != 0 || req_tvalid || expected_beats.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      logic [7:0] opening[0:22];
      // directed opening under reset registers (start 0xAA, limit 64):
      //   two noise bytes, empty frame with id 0xFF, two-byte frame whose
      //   payload holds the start byte, bad check, length one above the
      //   limit, and the start byte used as the id of an empty frame
      opening = '{8'h00, 8'h55,
                  8'hAA, 8'hFF, 8'h00, 8'hFF,
                  8'hAA, 8'h00, 8'h02, 8'hAA, 8'hFF, 8'h57,
                  8'hAA, 8'h01, 8'h00, 8'h00,
                  8'hAA, 8'h05, 8'h41,
                  8'hAA, 8'hAA, 8'h00, 8'hAA};
      reset_predictor();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // phase 1: sender idles 30%, receiver 80%
      set_config(START_BYTE_RESET, LENGTH_LIMIT_RESET);
      send_idle_pct = 30;
      recv_idle_pct = 80;
      foreach (opening[i]) tx_bytes.push_back(opening[i]);
      fill_phase(100, 1'b0);
      drain();

      // phase 2: roles swapped; zero start byte, zero limit (empty frames only)
      set_config(8'h00, 7'd0);
      send_idle_pct = 80;
      recv_idle_pct = 30;
      fill_phase(80, 1'b0);
      drain();

      // phase 3: no idling; limit above the store depth, so 64 is the cap
      set_config(8'hFF, 7'h7F);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      fill_phase(120, 1'b0);
      drain();

      // phase 4: random registers, long receiver hold-off while bytes keep coming
      set_config(8'($urandom_range(0, 255)), 7'($urandom_range(1, 64)));
      hold_go = 1'b1;
      fill_phase(100, 1'b1);
      drain();

      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
